// File: hdl/assert_macros.svh
// Assertion macros shared by the RTL of the stride prefetch table.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle, ignored during reset.
`define AST_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Antecedent implies consequent in the following cycle, ignored during reset.
`define AST_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// File: hdl/spt_pkg.sv
// Types and constants of the stride prefetch table.
// No dependencies; imported by stride_prefetch_table_core and tb_top.
`default_nettype none

package spt_pkg;

    // Table depth; a power of two, so the low PC bits select the entry.
    localparam int TABLE_ENTRIES = 128;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);

    // Entry modes; code 3 is never written and behaves as transient.
    typedef enum logic [1:0] {
        MODE_INITIAL   = 2'd0,
        MODE_TRANSIENT = 2'd1,
        MODE_STEADY    = 2'd2
    } t_mode;

    typedef enum logic {
        ST_IDLE   = 1'b0,
        ST_UPDATE = 1'b1
    } t_state;

    typedef struct packed {
        logic [63:0] load_pc;
        logic [63:0] access_address;
    } t_req;

    typedef struct packed {
        logic [63:0]        prefetch_address;
        logic signed [31:0] detected_stride;
        logic [63:0]        requesting_pc;
    } t_rsp;

    typedef struct packed {
        logic [63:0] last_address;
        logic [31:0] last_stride;
        t_mode       mode;
    } t_entry;

endpackage

`default_nettype wire

// File: hdl/stride_prefetch_table_core.sv
// Reference prediction table stride prefetcher: table memory, update logic
// and output register. Depends on spt_pkg and assert_macros.svh.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+--------
//  miss    | in        | i_req_valid / o_req_ready  | i_req
//  fetch   | out       | o_rsp_valid / i_rsp_ready  | o_rsp
//
// Each miss first reads its table entry from the synchronous memory,
// then computes the stride and writes the entry back in the update state.
// No new request is taken before that write-back, so accesses never overlap.
// Reset clears the per-entry valid bits at once; an entry never written
// reads as address zero, stride zero, mode initial.
// A prefetch that meets a full, unread output register stalls the update.
`default_nettype none
`include "assert_macros.svh"

module stride_prefetch_table_core
    import spt_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_req_valid,
    output logic      o_req_ready,
    input  wire t_req i_req,
    output logic      o_rsp_valid,
    input  wire logic i_rsp_ready,
    output t_rsp      o_rsp
);

    t_state r_state, n_state;

    t_entry             r_mem [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] r_valid;
    t_entry             r_rd_entry;
    logic               r_rd_valid;
    logic [IDX_W-1:0]   r_idx;
    logic [63:0]        r_pc;
    logic [63:0]        r_addr;

    t_rsp               r_out;
    logic               r_out_valid;

    logic               req_accept;
    logic               wr_en;
    logic               out_load;
    t_entry             cur_entry;
    logic [31:0]        n_stride;
    logic               hit;
    t_entry             n_entry;
    t_rsp               n_out;

    assign req_accept = i_req_valid && o_req_ready;

    // Entry as stored, or the reset value if never written.
    always_comb begin
        cur_entry = r_rd_valid ? r_rd_entry : t_entry'('0);
    end

    // Stride measured against the last address, compared with the old stride.
    always_comb begin
        n_stride              = r_addr[31:0] - cur_entry.last_address[31:0];
        hit                   = (cur_entry.mode != MODE_INITIAL)
                                && (n_stride == cur_entry.last_stride);
        n_entry.last_address  = r_addr;
        n_entry.last_stride   = n_stride;
        n_entry.mode          = hit ? MODE_STEADY : MODE_TRANSIENT;
        n_out.prefetch_address = r_addr + {{32{n_stride[31]}}, n_stride};
        n_out.detected_stride  = n_stride;
        n_out.requesting_pc    = r_pc;
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (req_accept) begin
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                if (wr_en) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Control outputs of the sequencer.
    always_comb begin
        o_req_ready = 1'b0;
        wr_en       = 1'b0;
        out_load    = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_req_ready = 1'b1;
            end
            ST_UPDATE: begin
                wr_en    = !(hit && r_out_valid && !i_rsp_ready);
                out_load = hit && wr_en;
            end
            default: begin
                o_req_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Capture the request fields.
    always_ff @(posedge i_clk) begin
        if (req_accept) begin
            r_idx  <= i_req.load_pc[IDX_W-1:0];
            r_pc   <= i_req.load_pc;
            r_addr <= i_req.access_address;
        end
    end

    // Table memory: one write and one registered read.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_idx] <= n_entry;
        end
        if (req_accept) begin
            r_rd_entry <= r_mem[i_req.load_pc[IDX_W-1:0]];
        end
    end

    // Per-entry valid bits, cleared by reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (wr_en) begin
                r_valid[r_idx] <= 1'b1;
            end
            if (req_accept) begin
                r_rd_valid <= r_valid[i_req.load_pc[IDX_W-1:0]];
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_rsp_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= n_out;
        end
    end

    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_out;

    // A request read in the idle state always goes on to its update cycle.
    `AST_NEXT(a_accept_to_update, i_clk, i_rst_n, req_accept, r_state == ST_UPDATE)
    // A stalled update stays put until its write-back can happen.
    `AST_NEXT(a_stall_holds, i_clk, i_rst_n, (r_state == ST_UPDATE) && !wr_en,
              r_state == ST_UPDATE)
    // A loaded prefetch carries the PC of the request that was being updated.
    `AST_NEXT(a_out_pc, i_clk, i_rst_n, out_load,
              r_out_valid && (r_out.requesting_pc == $past(r_pc)))
    // A prefetch is only produced together with a table write-back.
    `AST_SAME(a_load_writes, i_clk, i_rst_n, out_load, wr_en && hit)

endmodule

`default_nettype wire

// File: bench/tb_top.sv
// Self-checking bench for stride_prefetch_table_core: a directed miss sequence and then
// random miss streams, with every returned prefetch checked against a predicted table.
// Depends on spt_pkg; drives the block only through its ports.
`default_nettype none

module tb_top
    import spt_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int STREAMS        = 16;
    localparam int PHASE_ITEMS    = 510;

    // Predicted copy of the table; queues the prefetch each accepted miss should cause.
    class stride_predictor;
        logic [63:0] last_addr   [TABLE_ENTRIES];
        logic [31:0] last_stride [TABLE_ENTRIES];
        t_mode       mode        [TABLE_ENTRIES];
        t_rsp        due_prefetches [$];
        int          misses;
        int          checked;
        int          errors;

        function new();
            foreach (mode[i]) begin
                last_addr[i]   = '0;
                last_stride[i] = '0;
                mode[i]        = MODE_INITIAL;
            end
            misses  = 0;
            checked = 0;
            errors  = 0;
        endfunction

        // The comparison uses the stride stored before this miss overwrites it.
        function void note_miss(t_req r);
            logic [IDX_W-1:0] idx;
            logic [31:0]      stride;
            logic [31:0]      prior;
            t_mode            was;
            t_rsp             want;
            idx    = r.load_pc[IDX_W-1:0];
            stride = r.access_address[31:0] - last_addr[idx][31:0];
            prior  = last_stride[idx];
            was    = mode[idx];
            misses++;
            last_addr[idx]   = r.access_address;
            last_stride[idx] = stride;
            if (was == MODE_INITIAL || stride != prior) begin
                mode[idx] = MODE_TRANSIENT;
            end else begin
                mode[idx]              = MODE_STEADY;
                want.prefetch_address  = r.access_address + {{32{stride[31]}}, stride};
                want.detected_stride   = stride;
                want.requesting_pc     = r.load_pc;
                due_prefetches.push_back(want);
            end
        endfunction

        // Compares one accepted prefetch with the oldest prediction.
        function void check_prefetch(t_rsp got);
            t_rsp want;
            if (due_prefetches.size() == 0) begin
                errors++;
                $display("%0t: unexpected prefetch addr %h stride %h pc %h", $time,
                         got.prefetch_address, got.detected_stride, got.requesting_pc);
                return;
            end
            want = due_prefetches.pop_front();
            checked++;
            if (got !== want) begin
                errors++;
                $display("%0t: prefetch mismatch, expected addr %h stride %h pc %h", $time,
                         want.prefetch_address, want.detected_stride, want.requesting_pc);
                $display("%0t:                    actual   addr %h stride %h pc %h", $time,
                         got.prefetch_address, got.detected_stride, got.requesting_pc);
            end
        endfunction
    endclass

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_req_valid = 1'b0;
    t_req i_req       = '0;
    logic o_req_ready;
    logic o_rsp_valid;
    logic i_rsp_ready = 1'b0;
    t_rsp o_rsp;

    stride_predictor tracker = new();

    int req_idle_pct  = 0;
    int rsp_stall_pct = 0;
    int stall_cycles  = 0;

    logic [63:0] s_pc     [STREAMS];
    logic [63:0] s_addr   [STREAMS];
    logic [31:0] s_stride [STREAMS];

    stride_prefetch_table_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .o_rsp       (o_rsp)
    );

    // Clock, 8 ns period.
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Prefetch side: check accepted prefetches, then stall at random for the next edge.
    always @(posedge i_clk) begin
        if (i_rst_n && o_rsp_valid && i_rsp_ready) begin
            tracker.check_prefetch(o_rsp);
        end
        i_rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
    end

    // Watchdog on cycles in which neither channel moves anything.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_req_valid && o_req_ready) || (o_rsp_valid && i_rsp_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, stall_cycles);
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Mix of zero, unit, small word-sized and arbitrary 32-bit strides.
    function automatic logic [31:0] pick_stride();
        logic [31:0] mag;
        mag = 32'($urandom_range(1, 64)) << 3;
        case ($urandom_range(0, 4))
            0: begin
                return 32'd0;
            end
            1: begin
                return $urandom;
            end
            2: begin
                return mag;
            end
            3: begin
                return 32'd0 - mag;
            end
            default: begin
                return $urandom_range(0, 1) ? 32'h0000_0001 : 32'hFFFF_FFFF;
            end
        endcase
    endfunction

    function automatic void reseed_stream(int s);
        s_pc[s]     = rand64();
        s_addr[s]   = rand64();
        s_stride[s] = pick_stride();
    endfunction

    // Presents one miss request, optionally after a gap, and waits for acceptance.
    // Valid is left high so that back-to-back requests need no extra edge.
    task automatic send_miss(input logic [63:0] pc, input logic [63:0] addr);
        t_req r;
        r.load_pc        = pc;
        r.access_address = addr;
        if ($urandom_range(0, 99) < req_idle_pct) begin
            i_req_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_req_valid <= 1'b1;
        i_req       <= r;
        @(posedge i_clk);
        while (!o_req_ready) @(posedge i_clk);
        tracker.note_miss(r);
    endtask

    // Mostly regular streams per load, with broken sequences and pure noise mixed in.
    task automatic run_random(input int n_items, input bit with_pause);
        int          s;
        int          roll;
        logic [63:0] pc;
        logic [63:0] addr;
        for (int k = 0; k < n_items; k++) begin
            // Hold off new misses until every predicted prefetch has come back.
            if (with_pause && k == n_items / 2) begin
                i_req_valid <= 1'b0;
                @(posedge i_clk);
                while (tracker.due_prefetches.size() != 0) @(posedge i_clk);
            end
            roll = $urandom_range(0, 99);
            if (roll < 80) begin
                s = $urandom_range(0, STREAMS - 1);
                if ($urandom_range(0, 39) == 0) begin
                    reseed_stream(s);
                end else if ($urandom_range(0, 19) == 0) begin
                    s_stride[s] = pick_stride();
                end
                pc        = s_pc[s];
                addr      = s_addr[s];
                s_addr[s] = s_addr[s] + {{32{s_stride[s][31]}}, s_stride[s]};
            end else if (roll < 90) begin
                pc   = s_pc[$urandom_range(0, STREAMS - 1)];
                addr = rand64();
            end else begin
                pc   = rand64();
                addr = rand64();
            end
            send_miss(pc, addr);
        end
    endtask

    initial begin
        for (int s = 0; s < STREAMS; s++) begin
            reseed_stream(s);
        end
        req_idle_pct  = 32;
        rsp_stall_pct = 66;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Zero stride from a fresh entry: recorded first, then confirmed at the same address.
        send_miss(64'h0, 64'h0);
        send_miss(64'h0, 64'h0);
        // All-ones PC and address, then a confirmed stride of minus one.
        send_miss('1, '1);
        send_miss('1, 64'hFFFF_FFFF_FFFF_FFFE);
        send_miss('1, 64'hFFFF_FFFF_FFFF_FFFD);
        // Steady entry broken by a new stride, then confirmed again.
        send_miss(64'h0, 64'h40);
        send_miss(64'h0, 64'h80);
        // A PC that aliases onto the same entry continues its stream.
        send_miss(64'h8000_0000_0000_0000, 64'hC0);
        // Addresses and the prefetch address wrap at the top of the 64-bit space.
        send_miss(64'h5, 64'hFFFF_FFFF_FFFF_FF00);
        send_miss(64'h5, 64'hFFFF_FFFF_FFFF_FF40);
        send_miss(64'h5, 64'hFFFF_FFFF_FFFF_FF80);
        send_miss(64'h5, 64'hFFFF_FFFF_FFFF_FFC0);
        // Differences beyond 32 bits are truncated, here to a stride of zero.
        send_miss(64'h9, 64'h10);
        send_miss(64'h9, 64'h1_0000_0010);
        send_miss(64'h9, 64'h2_0000_0010);
        // Largest positive stride.
        send_miss(64'hB, 64'h0);
        send_miss(64'hB, 64'h7FFF_FFFF);
        send_miss(64'hB, 64'hFFFF_FFFE);
        // Most negative stride, measured from the reset address on the first miss.
        send_miss(64'hC, 64'h8000_0000);
        send_miss(64'hC, 64'h0);

        run_random(PHASE_ITEMS, 1'b0);
        req_idle_pct  = 66;
        rsp_stall_pct = 32;
        run_random(PHASE_ITEMS, 1'b1);
        req_idle_pct  = 0;
        rsp_stall_pct = 0;
        run_random(PHASE_ITEMS, 1'b0);

        // Drain the outstanding prefetches and leave time for any stray one.
        i_req_valid <= 1'b0;
        while (tracker.due_prefetches.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);

        $display("Sent %0d misses across three back-pressure profiles; %0d prefetches checked.",
                 tracker.misses, tracker.checked);
        $display("Errors found: %0d.", tracker.errors);
        if (tracker.errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

`default_nettype wire

// File: files.f
+incdir+hdl
hdl/spt_pkg.sv
hdl/stride_prefetch_table_core.sv
bench/tb_top.sv
